[rtl/core/gttcm_pkg.sv]
// shared constants and types for the gate tempo tracker
package gttcm_pkg;
  localparam int MULT_SEARCH_LIMIT = 20;
  localparam int MISS_LIMIT = 4;
  localparam int TIMER_BITS = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWING2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWING3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FINE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GATE = 3'd7;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [40:0] dividend;
    logic [5:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [40:0] quotient;
  } div_rsp_t;
endpackage

[rtl/core/gate_tempo_tracker_clock_multiplier_top.sv]
// top level of the gate tempo tracker with clock multiplier outputs
// usage:
//   s_axis carries one gate sample per item: gate_level (15b signed mV),
//   gate_connected. m_axis returns one result per item: three pulse
//   levels, the smoothed period in ticks Q24.8, the edge flag and misses.
//   a disconnected item goes from accept straight to the timer advance and
//   output steps; a connected item without a gate edge first passes the
//   subdivision and schmitt steps. an item with an edge walks the
//   multiple search, a multiply and a compare step per multiple, through a
//   single shared multiplier, then divides the timer by the matched
//   multiple in a bit-serial divider and smooths over two more
//   multiplier steps; when no multiple matches, the divider is skipped.
//   s_axis_tready is high only while the sequencer is idle, so one item
//   is in work at a time. a stalled receiver holds the result in the
//   output register; the next item is still taken and waits in its last
//   step until the register frees. configuration writes are taken any
//   time and must be made while idle. synchronous reset clears all
//   timers, period and pulse state and loads the register defaults;
//   there is no clearing pass.
module gate_tempo_tracker_clock_multiplier_top #(
  parameter int MULT_SEARCH_LIMIT = gttcm_pkg::MULT_SEARCH_LIMIT,
  parameter int MISS_LIMIT = gttcm_pkg::MISS_LIMIT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // gate_level[14:0], gate_connected[15]
  input  logic [15:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // beat_pulse[0], second_pulse[1], third_pulse[2], period_estimate[34:3],
  // edge_seen[35], miss_count[38:36]
  output logic [39:0]                      m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [gttcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gttcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int MW = $clog2(MULT_SEARCH_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_SUB1, S_SUB2, S_SUB3, S_SCHMITT, S_MUL, S_CMP, S_DIV,
    S_SM1, S_SM2, S_SMF, S_ADV, S_OUT
  } state_t;
  state_t state;

  // configuration
  logic [16:0] smooth_amount;
  logic [3:0]  second_divisor, third_divisor;
  logic [15:0] second_swing, third_swing, pulse_ticks;
  logic        fine_swing_mode;
  logic [13:0] gate_high;

  // tracker state
  logic signed [32:0] beat_timer;
  logic [31:0] first_timer, second_timer, third_timer, period_q8;
  logic [2:0]  misses;
  logic        schmitt_high;
  logic [15:0] pulse_rem [3];

  // item latch and work registers
  logic signed [14:0] level;
  logic        edge_flag;
  logic [MW-1:0] mult;
  logic [65:0] acc;
  logic [65:0] psq5;
  logic [40:0] cand;

  // shared multiplier: 34 x 33 unsigned
  logic [33:0] mul_a;
  logic [32:0] mul_b;
  logic [66:0] mul_p;
  assign mul_p = mul_a * mul_b;

  gttcm_pkg::div_req_t dreq;
  gttcm_pkg::div_rsp_t drsp;
  gttcm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // helpers
  function automatic logic [3:0] clamp_div(input logic [3:0] d);
    if (d == 4'd0) return 4'd1;
    if (d > 4'd8) return 4'd8;
    return d;
  endfunction

  function automatic logic [17:0] swing_eff(input logic [15:0] s, input logic fine);
    logic [15:0] c;
    c = (s > 16'd32768) ? 16'd32768 : s;
    return fine ? 18'(17'd49152 + 17'(c)) : {c, 2'b00};
  endfunction

  logic [3:0]  sub_div;
  logic [17:0] sub_sw;
  logic [31:0] sub_tmr;
  logic [16:0] a_sat;
  logic [40:0] abs_d;
  logic signed [40:0] diff;

  assign a_sat = (smooth_amount > 17'd65536) ? 17'd65536 : smooth_amount;
  assign sub_div = clamp_div(state == S_SUB2 ? second_divisor : third_divisor);
  assign sub_sw = state == S_SUB2 ? swing_eff(second_swing, fine_swing_mode)
                                  : swing_eff(third_swing, fine_swing_mode);
  assign sub_tmr = state == S_SUB2 ? second_timer : third_timer;
  assign diff = 41'(beat_timer) - 41'(acc[40:0]);
  assign abs_d = diff[40] ? 41'(-diff) : 41'(diff);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SUB1: begin mul_a = 34'(period_q8); mul_b = 33'(period_q8); end
      S_SUB2, S_SUB3: begin mul_a = 34'(period_q8); mul_b = 33'(sub_sw); end
      S_MUL: begin mul_a = 34'(period_q8); mul_b = 33'(mult); end
      S_CMP: begin mul_a = 34'(abs_d); mul_b = 33'(abs_d); end
      S_SM1: begin mul_a = 34'(17'd65536 - a_sat); mul_b = 33'(period_q8); end
      S_SM2: begin mul_a = 34'(a_sat); mul_b = 33'(cand); end
      default: ;
    endcase
  end

  logic [16:0] cfg_idle;
  assign cfg_idle = cfg_data;

  logic [33:0] np;
  logic [32:0] bt_sub;
  logic signed [34:0] bt_new;
  logic signed [34:0] bt_inc;
  logic [66:0] sub_lhs;
  logic        hit;
  logic        out_free;

  assign sub_lhs = {19'd0, sub_tmr, 16'd0} * 67'(sub_div);
  assign np = 34'((acc + 66'(mul_p) + 66'd32768) >> 16);
  assign bt_sub = 33'(period_q8);
  assign bt_new = 35'(beat_timer) - 35'(bt_sub);
  assign bt_inc = 35'(beat_timer) + 35'sd256;
  // 5*d^2 < p^2 with |d| < p
  assign hit = misses < 3'(MISS_LIMIT) && abs_d < 41'(period_q8) &&
               (67'(mul_p) * 67'd5) < 67'(psq5);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  function automatic logic [31:0] tinc(input logic [31:0] v);
    logic [32:0] s;
    s = 33'(v) + 33'd256;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] fire(input logic [15:0] r, input logic [15:0] pt);
    return (pt > r) ? pt : r;
  endfunction

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      smooth_amount <= 17'd32768;
      second_divisor <= 4'd2;
      third_divisor <= 4'd3;
      second_swing <= 16'd16384;
      third_swing <= 16'd16384;
      fine_swing_mode <= 1'b0;
      pulse_ticks <= 16'd480;
      gate_high <= 14'd1000;
      beat_timer <= '0;
      first_timer <= '0;
      second_timer <= '0;
      third_timer <= '0;
      period_q8 <= '0;
      misses <= '0;
      schmitt_high <= 1'b0;
      for (int k = 0; k < 3; k++) pulse_rem[k] <= '0;
      m_axis_tvalid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= (state == S_CMP) && hit;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          gttcm_pkg::REG_SMOOTH: smooth_amount <= cfg_idle;
          gttcm_pkg::REG_DIV2: second_divisor <= cfg_data[3:0];
          gttcm_pkg::REG_DIV3: third_divisor <= cfg_data[3:0];
          gttcm_pkg::REG_SWING2: second_swing <= cfg_data[15:0];
          gttcm_pkg::REG_SWING3: third_swing <= cfg_data[15:0];
          gttcm_pkg::REG_FINE: fine_swing_mode <= cfg_data[0];
          gttcm_pkg::REG_PULSE: pulse_ticks <= cfg_data[15:0];
          gttcm_pkg::REG_GATE: gate_high <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            level <= s_axis_tdata[14:0];
            edge_flag <= 1'b0;
            state <= s_axis_tdata[15] ? S_SUB1 : S_ADV;
          end
        end
        // beat subdivision, also latch p squared for the search
        S_SUB1: begin
          psq5 <= 66'(mul_p);
          if ({1'b0, first_timer} > {1'b0, period_q8}) begin
            pulse_rem[0] <= fire(pulse_rem[0], pulse_ticks);
            first_timer <= '0;
          end
          state <= S_SUB2;
        end
        S_SUB2: begin
          if (sub_lhs > mul_p) begin
            pulse_rem[1] <= fire(pulse_rem[1], pulse_ticks);
            second_timer <= '0;
          end
          state <= S_SUB3;
        end
        S_SUB3: begin
          if (sub_lhs > mul_p) begin
            pulse_rem[2] <= fire(pulse_rem[2], pulse_ticks);
            third_timer <= '0;
          end
          state <= S_SCHMITT;
        end
        // schmitt trigger and edge decision
        S_SCHMITT: begin
          state <= S_ADV;
          if (schmitt_high) begin
            if (level <= 15'sd0) schmitt_high <= 1'b0;
          end else if (16'(signed'(level)) >= signed'({2'b00, gate_high})) begin
            schmitt_high <= 1'b1;
            if (beat_timer > 33'sd0) begin
              edge_flag <= 1'b1;
              mult <= MW'(1);
              state <= S_MUL;
            end
          end
        end
        // multiple search: acc = m*p
        S_MUL: begin
          acc <= 66'(mul_p);
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            misses <= (mult == MW'(1)) ? 3'd0 : misses + 3'd1;
            dreq.dividend <= 41'(beat_timer) + 41'(mult >> 1);
            dreq.divisor <= 6'(mult);
            state <= S_DIV;
          end else if (mult == MW'(MULT_SEARCH_LIMIT - 1)) begin
            misses <= '0;
            cand <= 41'(beat_timer);
            state <= S_SM1;
          end else begin
            mult <= mult + MW'(1);
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            cand <= drsp.quotient;
            state <= S_SM1;
          end
        end
        // exponential smoothing
        S_SM1: begin
          acc <= 66'(mul_p);
          state <= S_SM2;
        end
        S_SM2: begin
          period_q8 <= np[33:32] != 2'b00 ? 32'hFFFF_FFFF : np[31:0];
          state <= S_SMF;
        end
        S_SMF: begin
          beat_timer <= bt_new < -35'sd4294967296 ? -33'sd4294967296
                                                  : 33'(bt_new);
          first_timer <= '0;
          second_timer <= '0;
          third_timer <= '0;
          for (int k = 0; k < 3; k++) pulse_rem[k] <= fire(pulse_rem[k], pulse_ticks);
          state <= S_ADV;
        end
        // timer advance
        S_ADV: begin
          beat_timer <= bt_inc > 35'sd4294967295 ? 33'sd4294967295 : 33'(bt_inc);
          first_timer <= tinc(first_timer);
          second_timer <= tinc(second_timer);
          third_timer <= tinc(third_timer);
          state <= S_OUT;
        end
        // wait here until the output register is free, then send and count the pulses down
        S_OUT: begin
          if (out_free) begin
            for (int k = 0; k < 3; k++) begin
              m_axis_tdata[k] <= pulse_rem[k] != 16'd0;
              if (pulse_rem[k] != 16'd0) pulse_rem[k] <= pulse_rem[k] - 16'd1;
            end
            m_axis_tdata[34:3] <= period_q8;
            m_axis_tdata[35] <= edge_flag;
            m_axis_tdata[38:36] <= misses;
            m_axis_tdata[39] <= 1'b0;
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a stalled result stays put
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // misses never exceed the limit
  a_miss_bound: assert property (@(posedge clk) disable iff (rst)
    misses <= 3'(MISS_LIMIT)) else $error("miss count out of range");
  // divider only finishes while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_DIV) else $error("stray divider result");
`endif
endmodule

[rtl/core/gttcm_div.sv]
// restoring divider, one quotient bit per cycle
module gttcm_div (
  input  logic                clk,
  input  logic                rst,
  input  gttcm_pkg::div_req_t req,
  output gttcm_pkg::div_rsp_t rsp
);
  logic [40:0] quo;
  logic [5:0]  rem;
  logic [5:0]  dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [6:0]  trial;

  assign trial = {rem, quo[40]};

  // shift and subtract loop
  always_ff @(posedge clk) begin
    done <= !rst && !req.start && busy && (cnt == 6'd1);
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= 6'd41;
      busy <= 1'b1;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 6'(trial - {1'b0, dvs});
        quo <= {quo[39:0], 1'b1};
      end else begin
        rem <= trial[5:0];
        quo <= {quo[39:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

[verif/gate_tempo_tracker_clock_multiplier_top_tb.sv]
// self-checking testbench for the gate tempo tracker with clock multiplier outputs
`timescale 1ns / 100ps

module gate_tempo_tracker_clock_multiplier_top_tb;

  typedef struct {
    bit        beat;
    bit        second;
    bit        third;
    bit [31:0] period;
    bit        edge_flag;
    bit [2:0]  misses;
  } tick_result_t;

  localparam longint TIMER_MAX = (64'd1 << gttcm_pkg::TIMER_BITS) - 1;
  localparam longint TIMER_MIN = -(64'sd1 << gttcm_pkg::TIMER_BITS);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // gate_level[14:0], gate_connected[15]
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // beat_pulse[0], second_pulse[1], third_pulse[2], period_estimate[34:3],
  // edge_seen[35], miss_count[38:36]
  logic [39:0] m_axis_tdata;
  logic                             cfg_we = 1'b0;
  logic [gttcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gttcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gate_tempo_tracker_clock_multiplier_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker copy: configuration
  bit [16:0] smooth_w = 17'd32768;
  bit [3:0]  div2 = 4'd2, div3 = 4'd3;
  bit [15:0] swing2 = 16'd16384, swing3 = 16'd16384;
  bit        fine_mode = 1'b0;
  bit [15:0] pulse_len = 16'd480;
  bit [13:0] gate_thr = 14'd1000;

  // tracker copy: state
  longint    beat_t = 0, sub1_t = 0, sub2_t = 0, sub3_t = 0;
  bit [31:0] period_q8 = '0;
  bit [2:0]  miss_cnt = '0;
  bit        gate_hi = 1'b0;
  bit [15:0] pulse_left [3] = '{16'd0, 16'd0, 16'd0};

  logic [15:0]  gate_items [$];
  tick_result_t expected_ticks [$];
  int errors = 0;
  int results_seen = 0;
  bit stim_done = 1'b0;

  function automatic longint clip_timer(longint v, longint lo);
    if (v > TIMER_MAX) return TIMER_MAX;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void trigger(int k);
    if (pulse_len > pulse_left[k]) pulse_left[k] = pulse_len;
  endfunction

  // true when a subdivision timer is past p*swing/div
  function automatic bit sub_due(longint tmr, bit [15:0] sw, bit [3:0] dv);
    longint unsigned d, s, eff;
    d = (dv < 1) ? 1 : (dv > 8) ? 8 : dv;
    s = (sw > 32768) ? 32768 : sw;
    eff = fine_mode ? (49152 + s) : s * 4;
    return (longint'(tmr) * 65536 * d) > (longint'(period_q8) * eff);
  endfunction

  // 5*(t - m*p)^2 < p^2
  function automatic bit near_mult(longint t, int m);
    longint unsigned p, ad, x, y;
    longint dlt;
    p = period_q8;
    dlt = t - longint'(m) * longint'(p);
    ad = (dlt < 0) ? -dlt : dlt;
    if (ad >= p) return 0;
    x = ad * ad;
    y = p * p;
    return (x < y / 5) || (x == y / 5 && (y % 5) > 0);
  endfunction

  function automatic void tempo_update();
    longint unsigned t, cand, a, np;
    bit found;
    t = beat_t;
    cand = t;
    a = (smooth_w > 65536) ? 65536 : smooth_w;
    found = 0;
    for (int m = 1; !found && m < gttcm_pkg::MULT_SEARCH_LIMIT; m++) begin
      if (miss_cnt < gttcm_pkg::MISS_LIMIT && near_mult(beat_t, m)) begin
        cand = (t + m / 2) / m;
        miss_cnt = (m == 1) ? 3'd0 : miss_cnt + 3'd1;
        found = 1;
      end
    end
    if (!found) miss_cnt = 0;
    np = ((65536 - a) * period_q8 + a * cand + 32768) >> 16;
    period_q8 = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : np[31:0];
    beat_t = clip_timer(beat_t - longint'(period_q8), TIMER_MIN);
    sub1_t = 0;
    sub2_t = 0;
    sub3_t = 0;
    for (int k = 0; k < 3; k++) trigger(k);
  endfunction

  // advance the tracker copy by one gate sample
  function automatic tick_result_t tracker_tick(logic [15:0] item);
    tick_result_t r;
    int lvl;
    bit rising;
    bit pl [3];
    lvl = $signed(item[14:0]);
    rising = 0;
    r.edge_flag = 0;
    if (item[15]) begin
      if (sub1_t > longint'(period_q8)) begin
        trigger(0);
        sub1_t = 0;
      end
      if (sub_due(sub2_t, swing2, div2)) begin
        trigger(1);
        sub2_t = 0;
      end
      if (sub_due(sub3_t, swing3, div3)) begin
        trigger(2);
        sub3_t = 0;
      end
      if (gate_hi) begin
        if (lvl <= 0) gate_hi = 0;
      end else if (lvl >= int'(gate_thr)) begin
        gate_hi = 1;
        rising = 1;
      end
      if (rising && beat_t > 0) begin
        tempo_update();
        r.edge_flag = 1;
      end
    end
    beat_t = clip_timer(beat_t + 256, TIMER_MIN);
    sub1_t = clip_timer(sub1_t + 256, 0);
    sub2_t = clip_timer(sub2_t + 256, 0);
    sub3_t = clip_timer(sub3_t + 256, 0);
    for (int k = 0; k < 3; k++) begin
      pl[k] = (pulse_left[k] > 0);
      if (pl[k]) pulse_left[k]--;
    end
    r.beat = pl[0];
    r.second = pl[1];
    r.third = pl[2];
    r.period = period_q8;
    r.misses = miss_cnt;
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_ticks.push_back(tracker_tick(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (gate_items.size() > 0) begin
          s_axis_tdata <= gate_items.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern, one long hold-off, and result checking
  int hold_left = 0;
  int mode_left = 0;
  bit stall_mode = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    tick_result_t e;
    logic [39:0] got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_ticks.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, actual %h", $time, got);
        end else begin
          e = expected_ticks.pop_front();
          if (got[38:0] != {e.misses, e.edge_flag, e.period, e.third, e.second, e.beat}) begin
            errors++;
            $display("%0t: mismatch expected beat=%0d second=%0d third=%0d period=%h edge=%0d miss=%0d",
                     $time, e.beat, e.second, e.third, e.period, e.edge_flag, e.misses);
            $display("%0t:          actual beat=%0d second=%0d third=%0d period=%h edge=%0d miss=%0d",
                     $time, got[0], got[1], got[2], got[34:3], got[35], got[38:36]);
          end
        end
      end
      if (!long_hold_done && results_seen == 400) begin
        long_hold_done = 1;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        stall_mode = ~stall_mode;
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  task automatic write_reg(logic [gttcm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[gttcm_pkg::CFG_DATA_W-1:0];
    case (idx)
      gttcm_pkg::REG_SMOOTH: smooth_w = val[16:0];
      gttcm_pkg::REG_DIV2:   div2 = val[3:0];
      gttcm_pkg::REG_DIV3:   div3 = val[3:0];
      gttcm_pkg::REG_SWING2: swing2 = val[15:0];
      gttcm_pkg::REG_SWING3: swing3 = val[15:0];
      gttcm_pkg::REG_FINE:   fine_mode = val[0];
      gttcm_pkg::REG_PULSE:  pulse_len = val[15:0];
      gttcm_pkg::REG_GATE:   gate_thr = val[13:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(int lvl, bit conn);
    logic [14:0] l;
    l = lvl[14:0];
    gate_items.push_back({conn, l});
  endtask

  task automatic wait_idle();
    wait (gate_items.size() == 0 && !s_axis_tvalid && expected_ticks.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  // periodic gate trains with dropped beats, jitter, noise and disconnects
  task automatic gate_train(int n);
    int per, hi_len, ph, top, lvl;
    bit conn;
    top = (gate_thr > 12000) ? 12000 : gate_thr;
    per = $urandom_range(4, 40);
    hi_len = $urandom_range(1, per - 1);
    ph = 0;
    for (int i = 0; i < n; i++) begin
      conn = ($urandom_range(0, 40) != 0);
      if ($urandom_range(0, 15) == 0) begin
        lvl = $urandom_range(0, 24000) - 12000;
      end else if (ph < hi_len) begin
        lvl = $urandom_range(top, 12000);
      end else begin
        lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12000) - 12000
              : ($urandom_range(0, 4) == 0) ? $urandom_range(1, top) : 0;
        if (ph == hi_len) lvl = -$urandom_range(0, 12000);
      end
      push_sample(lvl, conn);
      ph++;
      if (ph >= per) begin
        ph = ($urandom_range(0, 6) == 0) ? -per : $urandom_range(0, 1);
        if ($urandom_range(0, 20) == 0) begin
          per = $urandom_range(4, 40);
          hi_len = $urandom_range(1, per - 1);
        end
      end
    end
  endtask

  int unsigned phase_regs [6][8] = '{
    '{32768, 2, 3, 16384, 16384, 0, 3, 1000},
    '{65536, 1, 8, 0, 32768, 1, 1, 0},
    '{0, 0, 15, 65535, 20000, 0, 0, 12000},
    '{131071, 4, 5, 8000, 24000, 1, 65535, 16383},
    '{8192, 3, 7, 12000, 30000, 0, 6, 2500},
    '{0, 0, 0, 0, 0, 0, 0, 0}
  };

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed: thresholds, hysteresis, field extremes, disconnect
    push_sample(-12000, 1);
    push_sample(12000, 1);
    push_sample(1, 1);
    push_sample(0, 1);
    push_sample(999, 1);
    push_sample(1000, 1);
    push_sample(-1, 1);
    push_sample(-12000, 0);
    push_sample(12000, 0);
    push_sample(-5, 1);
    push_sample(1000, 1);
    push_sample(-16384, 1);
    push_sample(16383, 1);
    push_sample(0, 1);
    push_sample(5000, 1);
    push_sample(0, 1);
    push_sample(0, 1);
    push_sample(8000, 1);
    push_sample(-12000, 1);
    push_sample(1000, 1);
    wait_idle();
    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 8; r++) begin
        if (p == 5)
          write_reg(r[gttcm_pkg::CFG_IDX_W-1:0],
                    (r == 0) ? $urandom_range(0, 131071) : (r == 7) ? $urandom_range(0, 16383)
                    : (r == 5) ? $urandom_range(0, 1) : (r == 1 || r == 2) ? $urandom_range(0, 15)
                    : (r == 6) ? $urandom_range(0, 12) : $urandom_range(0, 65535));
        else
          write_reg(r[gttcm_pkg::CFG_IDX_W-1:0], phase_regs[p][r]);
      end
      for (int b = 0; b < 4; b++) gate_train(35);
      wait_idle();
    end
    stim_done = 1'b1;
    if (errors == 0) begin
      $display("gate_tempo_tracker_clock_multiplier_top regression: pass");
    end else begin
      $display("gate_tempo_tracker_clock_multiplier_top regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("gate_tempo_tracker_clock_multiplier_top regression: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/gttcm_pkg.sv
rtl/core/gttcm_div.sv
rtl/core/gate_tempo_tracker_clock_multiplier_top.sv
verif/gate_tempo_tracker_clock_multiplier_top_tb.sv
